@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the mpeg audio header scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked on clk_i and off during reset
`define MAHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication, clocked on clk_i and off during reset
`define MAHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/mahs_pkg.sv @@
// types, constants and header tables of the mpeg audio header scanner
package mahs_pkg;

  localparam int unsigned MaxScan  = 4096;
  localparam int unsigned LimitW   = $clog2(MaxScan + 1);
  localparam int unsigned CountW   = 12;
  localparam int unsigned MinLimit = 4;
  localparam logic [11:0] ScanLimitRst = 12'd1024;

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [2:0] SyncTop  = 3'b111;

  // raw version bits of the header
  localparam logic [1:0] VbitsMpeg25 = 2'b00;
  localparam logic [1:0] VbitsRsv    = 2'b01;
  localparam logic [1:0] VbitsMpeg2  = 2'b10;

  // decoded version codes
  localparam logic [1:0] VerMpeg1  = 2'd0;
  localparam logic [1:0] VerMpeg2  = 2'd1;
  localparam logic [1:0] VerMpeg25 = 2'd2;

  localparam logic [1:0] LbitsRsv = 2'b00;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RSV_VER   = 2'd1,
    STAT_RSV_LAYER = 2'd2,
    STAT_NO_SYNC   = 2'd3
  } status_e;

  // request handed from the scanner to the result stage
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [11:0] offset;
  } hit_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] header_offset;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [2:0]  flag_bits;
    logic [1:0]  emphasis;
  } res_t;

  localparam logic [8:0] BitrateTab [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [15:0] SampleRateTab [3][4] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd11025, 16'd12000, 16'd8000,  16'd0}
  };

  function automatic logic [8:0] bitrate_lookup(logic [2:0] row, logic [3:0] idx);
    logic [8:0] r;
    r = '0;
    if (row <= 3'd4) begin
      r = BitrateTab[row][idx];
    end
    return r;
  endfunction

  function automatic logic [15:0] sample_rate_lookup(logic [1:0] ver, logic [1:0] idx);
    logic [15:0] r;
    r = '0;
    if (ver <= VerMpeg25) begin
      r = SampleRateTab[ver][idx];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mahs_scan.sv @@
// input register, byte window, byte count and sync search
`include "assert_macros.svh"

module mahs_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_file_i,
  input  logic [11:0]       scan_limit_i,
  input  logic              adv_i,
  output mahs_pkg::hit_t    hit_o
);

  logic                          in_v_q;
  logic [7:0]                    byte_q;
  logic                          sof_q;
  logic [23:0]                   win_q, win_d, win_eff;
  logic [mahs_pkg::CountW-1:0]   cnt_q, cnt_d, cnt_eff;
  logic                          done_q, done_d, done_eff;
  logic [mahs_pkg::LimitW-1:0]   limit, next_idx;
  logic                          sync, at_limit, proc;

  assign in_stall_o = in_v_q && !adv_i;
  assign proc       = in_v_q && adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
      sof_q  <= start_of_file_i;
    end
  end

  always_comb begin
    // start of file restarts the scan before this byte is looked at
    win_eff  = sof_q ? '0 : win_q;
    cnt_eff  = sof_q ? '0 : cnt_q;
    done_eff = sof_q ? 1'b0 : done_q;

    limit = mahs_pkg::LimitW'(scan_limit_i);
    if (limit > mahs_pkg::LimitW'(mahs_pkg::MaxScan)) begin
      limit = mahs_pkg::LimitW'(mahs_pkg::MaxScan);
    end
    if (limit < mahs_pkg::LimitW'(mahs_pkg::MinLimit)) begin
      limit = mahs_pkg::LimitW'(mahs_pkg::MinLimit);
    end
    next_idx = mahs_pkg::LimitW'(cnt_eff) + mahs_pkg::LimitW'(1);

    sync = (cnt_eff >= mahs_pkg::CountW'(3)) && (win_eff[23:16] == mahs_pkg::SyncByte)
           && (win_eff[15:13] == mahs_pkg::SyncTop);
    at_limit = next_idx >= limit;

    hit_o.valid  = proc && !done_eff && (sync || at_limit);
    hit_o.found  = sync;
    hit_o.b1     = win_eff[15:8];
    hit_o.b2     = win_eff[7:0];
    hit_o.b3     = byte_q;
    hit_o.offset = cnt_eff - mahs_pkg::CountW'(3);

    win_d  = win_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (proc) begin
      win_d  = win_eff;
      cnt_d  = cnt_eff;
      done_d = done_eff;
      if (!done_eff) begin
        if (sync || at_limit) begin
          done_d = 1'b1;
        end else begin
          win_d = {win_eff[15:0], byte_q};
          cnt_d = cnt_eff + mahs_pkg::CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b1;
    end else begin
      win_q  <= win_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  `MAHS_ASSERT(a_done_after_hit, hit_o.valid |=> done_q, "scan not closed after a result")
  `MAHS_ASSERT(a_count_in_range, cnt_q != '1, "byte count ran past the scan range")

endmodule

@@ rtl/core/mahs_out.sv @@
// header field decode and result register
`include "assert_macros.svh"

module mahs_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mahs_pkg::hit_t        hit_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mahs_pkg::res_t        res_o
);

  logic            out_v_q;
  mahs_pkg::res_t  res_q, res_d;
  logic [1:0]      vbits, lbits, ver, layer;
  logic [2:0]      row;

  assign adv_o       = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

  always_comb begin
    vbits = hit_i.b1[4:3];
    lbits = hit_i.b1[2:1];
    case (vbits)
      mahs_pkg::VbitsMpeg25: ver = mahs_pkg::VerMpeg25;
      mahs_pkg::VbitsMpeg2:  ver = mahs_pkg::VerMpeg2;
      default:               ver = mahs_pkg::VerMpeg1;
    endcase
    layer = 2'(3'd4 - {1'b0, lbits});
    if (ver == mahs_pkg::VerMpeg1) begin
      row = {1'b0, layer} - 3'd1;
    end else begin
      row = (layer == 2'd1) ? 3'd3 : 3'd4;
    end

    res_d = '0;
    if (!hit_i.found) begin
      res_d.status = mahs_pkg::STAT_NO_SYNC;
    end else begin
      res_d.header_offset = hit_i.offset;
      if (vbits == mahs_pkg::VbitsRsv) begin
        res_d.status = mahs_pkg::STAT_RSV_VER;
      end else if (lbits == mahs_pkg::LbitsRsv) begin
        res_d.status = mahs_pkg::STAT_RSV_LAYER;
      end else begin
        res_d.status         = mahs_pkg::STAT_OK;
        res_d.version        = ver;
        res_d.layer          = layer;
        res_d.crc_protected  = ~hit_i.b1[0];
        res_d.bitrate_kbps   = mahs_pkg::bitrate_lookup(row, hit_i.b2[7:4]);
        res_d.sample_rate_hz = mahs_pkg::sample_rate_lookup(ver, hit_i.b2[3:2]);
        res_d.padding        = hit_i.b2[1];
        res_d.channel_mode   = hit_i.b3[7:6];
        res_d.mode_extension = hit_i.b3[5:4];
        res_d.flag_bits      = {hit_i.b2[0], hit_i.b3[3], hit_i.b3[2]};
        res_d.emphasis       = hit_i.b3[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_o) begin
      out_v_q <= hit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && hit_i.valid) begin
      res_q <= res_d;
    end
  end

  `MAHS_ASSERT_IMP(a_nosync_clean, out_v_q && res_q.status == mahs_pkg::STAT_NO_SYNC,
    res_q.header_offset == '0 && res_q.bitrate_kbps == '0, "not-found result carries data")

endmodule

@@ rtl/core/mpeg_audio_header_scanner.sv @@
// the byte that completes the header passes the input register, then the result register, before its result is valid
// throughput: one byte request per cycle while in_stall_o is low, results drain through one result register
// rate set by the single pass from the input register through decode to the result register
// reset: scan idle until a start of file byte, scan limit 1024, no result pending
module mpeg_audio_header_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] header_offset_o,
  output logic [1:0]  version_o,
  output logic [1:0]  layer_o,
  output logic        crc_protected_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic        padding_o,
  output logic [1:0]  channel_mode_o,
  output logic [1:0]  mode_extension_o,
  output logic [2:0]  flag_bits_o,
  output logic [1:0]  emphasis_o
);

  logic [11:0]     scan_limit_q;
  logic            adv;
  mahs_pkg::hit_t  hit;
  mahs_pkg::res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= mahs_pkg::ScanLimitRst;
    end else if (cfg_we_i) begin
      scan_limit_q <= cfg_wdata_i;
    end
  end

  mahs_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .scan_limit_i    (scan_limit_q),
    .adv_i           (adv),
    .hit_o           (hit)
  );

  mahs_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_i       (hit),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o         = res.status;
  assign header_offset_o  = res.header_offset;
  assign version_o        = res.version;
  assign layer_o          = res.layer;
  assign crc_protected_o  = res.crc_protected;
  assign bitrate_kbps_o   = res.bitrate_kbps;
  assign sample_rate_hz_o = res.sample_rate_hz;
  assign padding_o        = res.padding;
  assign channel_mode_o   = res.channel_mode;
  assign mode_extension_o = res.mode_extension;
  assign flag_bits_o      = res.flag_bits;
  assign emphasis_o       = res.emphasis;

endmodule
